[rtl/fatct_pkg.sv]
// ----------------------------------------------------------------------------
// fatct_pkg
// Types, widths and codes shared by the cluster chain table block.
// ----------------------------------------------------------------------------
package fatct_pkg;

   localparam int FAT_ENTRIES_DEFAULT = 65536;

   localparam int OP_W       = 2;
   localparam int CLUSTER_W  = 28;
   localparam int SECTOR_W   = 32;
   localparam int STATUS_W   = 2;
   localparam int CS_W       = 8;
   localparam int FEC_W      = 17;
   localparam int BOUND_W    = 29;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 4;

   localparam logic [CLUSTER_W-1:0] END_MARK      = 28'hFFFFFF8;
   localparam logic [CLUSTER_W-1:0] FIRST_CLUSTER = 28'd2;

   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
   localparam logic [OP_W-1:0] OP_SET    = 2'd1;
   localparam logic [OP_W-1:0] OP_ALLOC  = 2'd2;
   localparam logic [OP_W-1:0] OP_FREE   = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

   localparam logic [1:0] REG_DATA_START  = 2'd0;
   localparam logic [1:0] REG_CLUSTER_SEC = 2'd1;
   localparam logic [1:0] REG_ENTRY_COUNT = 2'd2;

   localparam logic [CS_W-1:0]  CS_RESET  = 8'd1;
   localparam logic [FEC_W-1:0] FEC_RESET = 17'd65536;

   typedef enum logic [2:0] {
      RK_LOOKUP,
      RK_ALLOC,
      RK_OK,
      RK_RANGE,
      RK_FULL
   } result_kind_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_SCAN,
      S_ALLOC_WAIT,
      S_FREE_CHECK,
      S_FREE_DATA,
      S_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic            load_req;
      logic            clr_step;
      logic            rd_cur;
      logic            set_write;
      logic            scan;
      logic            free_write;
      logic            kind_we;
      result_kind_type kind;
      logic            out_load;
   } dp_cmd_type;

   typedef struct packed {
      logic            clr_last;
      logic [OP_W-1:0] op;
      logic            in_range;
      logic            chain_end;
      logic            scan_found;
      logic            scan_empty;
      logic            out_free;
   } dp_sts_type;

endpackage

[rtl/fatct_req_if.sv]
// ----------------------------------------------------------------------------
// fatct_req_if
// Request channel: operation, cluster index and entry value.
// ----------------------------------------------------------------------------
interface fatct_req_if;
   import fatct_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      operation;
   logic [CLUSTER_W-1:0] cluster_index;
   logic [CLUSTER_W-1:0] entry_value;

   modport source (output valid, output operation, output cluster_index,
                   output entry_value, input ready);
   modport sink   (input valid, input operation, input cluster_index,
                   input entry_value, output ready);
endinterface

[rtl/fatct_rsp_if.sv]
// ----------------------------------------------------------------------------
// fatct_rsp_if
// Response channel: result cluster, first sector, end-of-chain flag, status.
// ----------------------------------------------------------------------------
interface fatct_rsp_if;
   import fatct_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CLUSTER_W-1:0] result_cluster;
   logic [SECTOR_W-1:0]  first_sector;
   logic                 end_of_chain;
   logic [STATUS_W-1:0]  status;

   modport source (output valid, output result_cluster, output first_sector,
                   output end_of_chain, output status, input ready);
   modport sink   (input valid, input result_cluster, input first_sector,
                   input end_of_chain, input status, output ready);
endinterface

[rtl/fat32_cluster_chain_table_core.sv]
// Lookup and set: S_DECODE, then S_DONE registers the result; one at a time.
// Allocate: one table entry examined per cycle through the RAM read port.
// Free chain: a read (S_FREE_CHECK) and a write (S_FREE_DATA) per cluster.
// Reset: synchronous; a clearing pass writes every one of FAT_ENTRIES entries,
//   one per cycle, with req ready held low meanwhile.
// ----------------------------------------------------------------------------
// fat32_cluster_chain_table_core
// FAT32 allocation table with lookup, set, allocate and free-chain operations.
// ----------------------------------------------------------------------------
module fat32_cluster_chain_table_core #(
   parameter int FAT_ENTRIES = fatct_pkg::FAT_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   fatct_req_if.sink                         req_chan,
   fatct_rsp_if.source                       rsp_chan,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [fatct_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fatct_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fatct_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                              pready
);
   import fatct_pkg::*;

   dp_cmd_type           cmd;
   dp_sts_type           sts;
   logic [SECTOR_W-1:0]  data_start_sector;
   logic [CS_W-1:0]      cluster_sectors;
   logic [BOUND_W-1:0]   table_bound;

   fatct_csr #(
      .FAT_ENTRIES (FAT_ENTRIES)
   ) u_csr (
      .clock             (clock),
      .reset             (reset),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready),
      .data_start_sector (data_start_sector),
      .cluster_sectors   (cluster_sectors),
      .table_bound       (table_bound)
   );

   fatct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   fatct_dp #(
      .FAT_ENTRIES (FAT_ENTRIES)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_operation      (req_chan.operation),
      .req_cluster_index  (req_chan.cluster_index),
      .req_entry_value    (req_chan.entry_value),
      .data_start_sector  (data_start_sector),
      .cluster_sectors    (cluster_sectors),
      .table_bound        (table_bound),
      .rsp_ready          (rsp_chan.ready),
      .rsp_valid          (rsp_chan.valid),
      .rsp_result_cluster (rsp_chan.result_cluster),
      .rsp_first_sector   (rsp_chan.first_sector),
      .rsp_end_of_chain   (rsp_chan.end_of_chain),
      .rsp_status         (rsp_chan.status)
   );
endmodule

[rtl/fatct_ram.sv]
// ----------------------------------------------------------------------------
// fatct_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fatct_ram #(
   parameter int WIDTH = 28,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/fatct_csr.sv]
// ----------------------------------------------------------------------------
// fatct_csr
// Configuration registers on an APB-style port; derives the table bound.
// ----------------------------------------------------------------------------
module fatct_csr #(
   parameter int FAT_ENTRIES = fatct_pkg::FAT_ENTRIES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [fatct_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [fatct_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [fatct_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                                pready,
   output logic [fatct_pkg::SECTOR_W-1:0]      data_start_sector,
   output logic [fatct_pkg::CS_W-1:0]          cluster_sectors,
   output logic [fatct_pkg::BOUND_W-1:0]       table_bound
);
   import fatct_pkg::*;

   localparam logic [BOUND_W-1:0] ENTRIES_B = BOUND_W'(FAT_ENTRIES);

   logic [SECTOR_W-1:0] dss_ff, dss_in;
   logic [CS_W-1:0]     cs_ff, cs_in;
   logic [FEC_W-1:0]    fec_ff, fec_in;
   logic                wr_strobe;
   logic [1:0]          reg_idx;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[3:2];
   assign wr_strobe = psel && penable && pwrite;

   always_comb begin
      dss_in = dss_ff;
      cs_in  = cs_ff;
      fec_in = fec_ff;
      if (wr_strobe) begin
         case (reg_idx)
            REG_DATA_START:  dss_in = pwdata;
            REG_CLUSTER_SEC: cs_in  = pwdata[CS_W-1:0];
            REG_ENTRY_COUNT: fec_in = pwdata[FEC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dss_ff <= '0;
         cs_ff  <= CS_RESET;
         fec_ff <= FEC_RESET;
      end else begin
         dss_ff <= dss_in;
         cs_ff  <= cs_in;
         fec_ff <= fec_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_DATA_START:  prdata = dss_ff;
         REG_CLUSTER_SEC: prdata = CSR_DATA_W'(cs_ff);
         REG_ENTRY_COUNT: prdata = CSR_DATA_W'(fec_ff);
         default:         prdata = '0;
      endcase
   end

   always_comb begin
      if (fec_ff == '0 || BOUND_W'(fec_ff) > ENTRIES_B) begin
         table_bound = ENTRIES_B;
      end else begin
         table_bound = BOUND_W'(fec_ff);
      end
   end

   assign data_start_sector = dss_ff;
   assign cluster_sectors   = cs_ff;
endmodule

[rtl/fatct_ctrl.sv]
// ----------------------------------------------------------------------------
// fatct_ctrl
// Sequencer: clearing pass, decode, allocation scan, chain free, result hand-off.
// ----------------------------------------------------------------------------
module fatct_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   output fatct_pkg::dp_cmd_type cmd,
   input  fatct_pkg::dp_sts_type sts
);
   import fatct_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.kind  = RK_OK;
      req_ready = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            cmd.kind_we = 1'b1;
            case (sts.op)
               OP_LOOKUP: begin
                  if (sts.in_range) begin
                     cmd.rd_cur = 1'b1;
                     cmd.kind   = RK_LOOKUP;
                  end else begin
                     cmd.kind = RK_RANGE;
                  end
                  state_in = S_DONE;
               end
               OP_SET: begin
                  if (sts.in_range) begin
                     cmd.set_write = 1'b1;
                     cmd.kind      = RK_OK;
                  end else begin
                     cmd.kind = RK_RANGE;
                  end
                  state_in = S_DONE;
               end
               OP_ALLOC: begin
                  cmd.kind_we = 1'b0;
                  state_in    = S_SCAN;
               end
               default: begin
                  cmd.kind_we = 1'b0;
                  state_in    = S_FREE_CHECK;
               end
            endcase
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_found) begin
               cmd.kind_we = 1'b1;
               cmd.kind    = RK_ALLOC;
               state_in    = S_ALLOC_WAIT;
            end else if (sts.scan_empty) begin
               cmd.kind_we = 1'b1;
               cmd.kind    = RK_FULL;
               state_in    = S_DONE;
            end
         end
         S_ALLOC_WAIT: begin
            state_in = S_DONE;
         end
         S_FREE_CHECK: begin
            if (sts.chain_end) begin
               cmd.kind_we = 1'b1;
               cmd.kind    = RK_OK;
               state_in    = S_DONE;
            end else if (!sts.in_range) begin
               cmd.kind_we = 1'b1;
               cmd.kind    = RK_RANGE;
               state_in    = S_DONE;
            end else begin
               cmd.rd_cur = 1'b1;
               state_in   = S_FREE_DATA;
            end
         end
         S_FREE_DATA: begin
            cmd.free_write = 1'b1;
            state_in       = S_FREE_CHECK;
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end
endmodule

[rtl/fatct_dp.sv]
// ----------------------------------------------------------------------------
// fatct_dp
// Datapath: table RAM, walk and scan pointers, sector arithmetic, result register.
// ----------------------------------------------------------------------------
module fatct_dp #(
   parameter int FAT_ENTRIES = fatct_pkg::FAT_ENTRIES_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  fatct_pkg::dp_cmd_type             cmd,
   output fatct_pkg::dp_sts_type             sts,
   input  logic [fatct_pkg::OP_W-1:0]        req_operation,
   input  logic [fatct_pkg::CLUSTER_W-1:0]   req_cluster_index,
   input  logic [fatct_pkg::CLUSTER_W-1:0]   req_entry_value,
   input  logic [fatct_pkg::SECTOR_W-1:0]    data_start_sector,
   input  logic [fatct_pkg::CS_W-1:0]        cluster_sectors,
   input  logic [fatct_pkg::BOUND_W-1:0]     table_bound,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [fatct_pkg::CLUSTER_W-1:0]   rsp_result_cluster,
   output logic [fatct_pkg::SECTOR_W-1:0]    rsp_first_sector,
   output logic                              rsp_end_of_chain,
   output logic [fatct_pkg::STATUS_W-1:0]    rsp_status
);
   import fatct_pkg::*;

   localparam int            AW        = $clog2(FAT_ENTRIES);
   localparam int            PTR_W     = AW + 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(FAT_ENTRIES - 1);

   logic [OP_W-1:0]      op_ff, op_in;
   logic [CLUSTER_W-1:0] cur_ff, cur_in;
   logic [CLUSTER_W-1:0] val_ff, val_in;
   logic [CLUSTER_W-1:0] sec_c_ff, sec_c_in;
   logic [SECTOR_W-1:0]  product_ff, product_in;
   logic [PTR_W-1:0]     issue_ptr_ff, issue_ptr_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [AW-1:0]        pend_addr_ff, pend_addr_in;
   result_kind_type      kind_ff, kind_in;
   logic [AW-1:0]        clr_ptr_ff, clr_ptr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CLUSTER_W-1:0] res_ff, res_in;
   logic [SECTOR_W-1:0]  sec_ff, sec_in;
   logic                 eoc_ff, eoc_in;
   logic [STATUS_W-1:0]  st_ff, st_in;

   logic                 wr_en;
   logic [AW-1:0]        wr_addr;
   logic [CLUSTER_W-1:0] wr_data;
   logic                 rd_en;
   logic [AW-1:0]        rd_addr;
   logic [CLUSTER_W-1:0] rd_data;

   logic                 scan_more;
   logic                 scan_found;
   logic [SECTOR_W-1:0]  sector_sum;
   logic [SECTOR_W-1:0]  sec_diff;

   fatct_ram #(
      .WIDTH (CLUSTER_W),
      .DEPTH (FAT_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign scan_more  = BOUND_W'(issue_ptr_ff) < table_bound;
   assign scan_found = pend_valid_ff && (rd_data == '0);

   assign sts.clr_last   = (clr_ptr_ff == LAST_ADDR);
   assign sts.op         = op_ff;
   assign sts.in_range   = BOUND_W'(cur_ff) < table_bound;
   assign sts.chain_end  = (cur_ff < FIRST_CLUSTER) || (cur_ff >= END_MARK);
   assign sts.scan_found = scan_found;
   assign sts.scan_empty = !pend_valid_ff && !scan_more;
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   // table write and read port selection
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = cur_ff[AW-1:0];
      wr_data = '0;
      if (cmd.clr_step) begin
         wr_en   = 1'b1;
         wr_addr = clr_ptr_ff;
      end else if (cmd.set_write) begin
         wr_en   = 1'b1;
         wr_data = val_ff;
      end else if (cmd.scan && scan_found) begin
         wr_en   = 1'b1;
         wr_addr = pend_addr_ff;
         wr_data = END_MARK;
      end else if (cmd.free_write) begin
         wr_en = 1'b1;
      end
   end

   always_comb begin
      rd_en   = 1'b0;
      rd_addr = cur_ff[AW-1:0];
      if (cmd.rd_cur) begin
         rd_en = 1'b1;
      end else if (cmd.scan && !scan_found && scan_more) begin
         rd_en   = 1'b1;
         rd_addr = issue_ptr_ff[AW-1:0];
      end
   end

   // first sector = start + (cluster - 2) * sectors per cluster, mod 2^32
   assign sec_diff   = SECTOR_W'(sec_c_ff) - SECTOR_W'(FIRST_CLUSTER);
   assign product_in = sec_diff * SECTOR_W'(cluster_sectors);
   assign sector_sum = data_start_sector + product_ff;

   always_comb begin
      op_in         = op_ff;
      cur_in        = cur_ff;
      val_in        = val_ff;
      sec_c_in      = sec_c_ff;
      issue_ptr_in  = issue_ptr_ff;
      pend_valid_in = pend_valid_ff;
      pend_addr_in  = pend_addr_ff;
      kind_in       = kind_ff;
      clr_ptr_in    = clr_ptr_ff;
      rsp_valid_in  = rsp_valid_ff;
      res_in        = res_ff;
      sec_in        = sec_ff;
      eoc_in        = eoc_ff;
      st_in         = st_ff;

      if (cmd.load_req) begin
         op_in         = req_operation;
         cur_in        = req_cluster_index;
         val_in        = req_entry_value;
         sec_c_in      = req_cluster_index;
         issue_ptr_in  = PTR_W'(FIRST_CLUSTER);
         pend_valid_in = 1'b0;
      end

      if (cmd.clr_step) begin
         clr_ptr_in = clr_ptr_ff + AW'(1);
      end

      if (cmd.scan) begin
         if (scan_found) begin
            sec_c_in      = CLUSTER_W'(pend_addr_ff);
            pend_valid_in = 1'b0;
         end else if (scan_more) begin
            issue_ptr_in  = issue_ptr_ff + PTR_W'(1);
            pend_valid_in = 1'b1;
            pend_addr_in  = issue_ptr_ff[AW-1:0];
         end else begin
            pend_valid_in = 1'b0;
         end
      end

      if (cmd.free_write) begin
         cur_in = rd_data;
      end

      if (cmd.kind_we) begin
         kind_in = cmd.kind;
      end

      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         res_in       = '0;
         sec_in       = '0;
         st_in        = ST_OK;
         case (kind_ff)
            RK_LOOKUP: begin
               res_in = rd_data;
               sec_in = sector_sum;
            end
            RK_ALLOC: begin
               res_in = sec_c_ff;
               sec_in = sector_sum;
            end
            RK_RANGE: st_in = ST_RANGE;
            RK_FULL:  st_in = ST_FULL;
            default:  ;
         endcase
         eoc_in = (res_in >= END_MARK);
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ptr_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ptr_ff   <= clr_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      cur_ff        <= cur_in;
      val_ff        <= val_in;
      sec_c_ff      <= sec_c_in;
      product_ff    <= product_in;
      issue_ptr_ff  <= issue_ptr_in;
      pend_valid_ff <= pend_valid_in;
      pend_addr_ff  <= pend_addr_in;
      kind_ff       <= kind_in;
      res_ff        <= res_in;
      sec_ff        <= sec_in;
      eoc_ff        <= eoc_in;
      st_ff         <= st_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_cluster = res_ff;
   assign rsp_first_sector   = sec_ff;
   assign rsp_end_of_chain   = eoc_ff;
   assign rsp_status         = st_ff;
endmodule
